// ===== sv/ssp_pkg.sv =====
// Shared constants and codes for the shortest-path engine.
`default_nettype none
package ssp_pkg;
   localparam int MAX_NODES_DEF   = 256;
   localparam int MAX_EDGES_DEF   = 512;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam int DIST_BITS = 24;
   localparam int SUM_BITS  = 33;
   localparam int CMP_BITS  = 14;  // wide enough to compare any node number to MAX_NODES

   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_SOLVE = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_OOR  = 2'd2;
   localparam logic [1:0] ST_BAD  = 2'd3;

   localparam logic [1:0] CSR_SOURCE = 2'd0;
   localparam logic [1:0] CSR_COUNT  = 2'd1;

   localparam logic [7:0] SOURCE_RST = 8'd1;
   localparam logic [7:0] COUNT_RST  = 8'd255;
endpackage : ssp_pkg
`default_nettype wire

// ===== sv/ssp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ssp_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule : ssp_ram
`default_nettype wire

// ===== sv/single_source_shortest_path.sv =====
// Dijkstra shortest-path engine over an edge list held in RAM.
// Clear, add edge and out-of-range requests go straight to the response state; a distance
// read first passes a RAM read state. Solve: per settled node a scan of all nodes, then
// each stored edge in turn; one final scan, then a sum over nodes 1..node_count.
// One request at a time; req_stall is high while a request is in progress.
// Reset (synchronous, active high) empties the graph, marks all nodes unreachable.
`default_nettype none
module single_source_shortest_path
   import ssp_pkg::*;
#(
   parameter int MAX_NODES   = MAX_NODES_DEF,
   parameter int MAX_EDGES   = MAX_EDGES_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // configuration
   input  wire logic                csr_wr_en,
   input  wire logic [1:0]          csr_index,
   input  wire logic [7:0]          csr_wdata,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [7:0]          req_node_a,
   input  wire logic [7:0]          req_node_b,
   input  wire logic [15:0]         req_weight,
   // response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [DIST_BITS-1:0]     rsp_distance,
   output logic                     rsp_reachable,
   output logic [SUM_BITS-1:0]      rsp_distance_sum
);
   // node index, edge count, edge address, edge entry, relax sum and sum counter widths
   localparam int NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int ETW  = $clog2(MAX_EDGES + 1);
   localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EWID = 2 * NW + WEIGHT_BITS;
   localparam int SW   = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;
   localparam int KW   = 9;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_RD      = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_RELAX_A = 3'd3;
   localparam logic [2:0] S_RELAX_B = 3'd4;
   localparam logic [2:0] S_RELAX_C = 3'd5;
   localparam logic [2:0] S_SUM     = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [7:0]             source_ff, source_in;
   logic [7:0]             count_ff, count_in;
   logic [ETW-1:0]         edge_total_ff, edge_total_in;
   logic [MAX_NODES-1:0]   dvalid_ff, dvalid_in;     // node has a tentative distance
   logic [MAX_NODES-1:0]   settled_ff, settled_in;
   logic [NW:0]            scan_ff, scan_in;
   logic                   found_ff, found_in;
   logic [NW-1:0]          best_ff, best_in;
   logic [DIST_BITS-1:0]   bestd_ff, bestd_in;
   logic [ETW-1:0]         e_ff, e_in;
   logic [NW-1:0]          other_ff, other_in;
   logic [WEIGHT_BITS-1:0] w_ff, w_in;
   logic [KW-1:0]          k_ff, k_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic                   reach_ff, reach_in;
   logic [1:0]             res_status_ff, res_status_in;
   logic [DIST_BITS-1:0]   res_dist_ff, res_dist_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [DIST_BITS-1:0]   rsp_distance_ff, rsp_distance_in;
   logic                   rsp_reachable_ff, rsp_reachable_in;
   logic [SUM_BITS-1:0]    rsp_sum_ff, rsp_sum_in;

   // RAM ports
   logic                   dist_we;
   logic [NW-1:0]          dist_wa, dist_ra;
   logic [DIST_BITS-1:0]   dist_wd, dist_rd;
   logic                   edge_we;
   logic [EWID-1:0]        edge_wd, edge_rd;

   logic                   req_accept, out_free;
   logic                   a_oor, b_oor, src_oor, full;
   logic [NW-1:0]          prev_idx, ea, eb, sum_idx;
   logic [WEIGHT_BITS-1:0] ew;
   logic                   hit;
   logic [SW-1:0]          nd_wide;
   logic [DIST_BITS-1:0]   nd;
   logic [KW-1:0]          k_prev, k_last;
   logic                   last_edge;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == S_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;

   assign a_oor   = CMP_BITS'(req_node_a) >= CMP_BITS'(MAX_NODES);
   assign b_oor   = CMP_BITS'(req_node_b) >= CMP_BITS'(MAX_NODES);
   assign src_oor = CMP_BITS'(source_ff) >= CMP_BITS'(MAX_NODES);
   assign full    = edge_total_ff >= ETW'(MAX_EDGES);

   assign edge_wd = {NW'(req_node_a), NW'(req_node_b), WEIGHT_BITS'(req_weight)};

   // stored edge fields
   assign ea  = edge_rd[EWID-1 -: NW];
   assign eb  = edge_rd[WEIGHT_BITS +: NW];
   assign ew  = edge_rd[WEIGHT_BITS-1:0];
   assign hit = (ea == best_ff) || (eb == best_ff);

   // relaxation: saturating add of settled distance and edge weight
   assign nd_wide = SW'(bestd_ff) + SW'(w_ff);
   assign nd      = (nd_wide > SW'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(nd_wide);

   assign prev_idx  = NW'(scan_ff - 1'b1);
   assign k_prev    = k_ff - 1'b1;
   assign k_last    = KW'(count_ff) + 1'b1;
   assign sum_idx   = NW'(k_prev);
   assign last_edge = (e_ff + 1'b1) == edge_total_ff;

   always_comb begin
      state_in         = state_ff;
      source_in        = source_ff;
      count_in         = count_ff;
      edge_total_in    = edge_total_ff;
      dvalid_in        = dvalid_ff;
      settled_in       = settled_ff;
      scan_in          = scan_ff;
      found_in         = found_ff;
      best_in          = best_ff;
      bestd_in         = bestd_ff;
      e_in             = e_ff;
      other_in         = other_ff;
      w_in             = w_ff;
      k_in             = k_ff;
      sum_in           = sum_ff;
      reach_in         = reach_ff;
      res_status_in    = res_status_ff;
      res_dist_in      = res_dist_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_distance_in  = rsp_distance_ff;
      rsp_reachable_in = rsp_reachable_ff;
      rsp_sum_in       = rsp_sum_ff;
      dist_we          = 1'b0;
      dist_wa          = other_ff;
      dist_wd          = nd;
      dist_ra          = NW'(req_node_a);
      edge_we          = 1'b0;

      // configuration writes only come while idle; the user must keep to this, the block does not enforce it
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SOURCE: source_in = csr_wdata;
            CSR_COUNT:  count_in  = csr_wdata;
            default:    ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_status_in = ST_OK;
               res_dist_in   = '0;
               reach_in      = 1'b0;
               sum_in        = '0;
               state_in      = S_DONE;
               case (req_cmd)
                  CMD_CLEAR: begin
                     edge_total_in = '0;
                     dvalid_in     = '0;
                     settled_in    = '0;
                  end
                  CMD_ADD: begin
                     if (a_oor || b_oor) begin
                        res_status_in = ST_OOR;
                     end else if (full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        edge_we       = 1'b1;
                        edge_total_in = edge_total_ff + 1'b1;
                     end
                  end
                  CMD_SOLVE: begin
                     if (src_oor) begin
                        res_status_in = ST_OOR;
                     end else begin
                        dvalid_in                = '0;
                        dvalid_in[NW'(source_ff)] = 1'b1;
                        settled_in               = '0;
                        dist_we                  = 1'b1;
                        dist_wa                  = NW'(source_ff);
                        dist_wd                  = '0;
                        scan_in                  = '0;
                        found_in                 = 1'b0;
                        state_in                 = S_SCAN;
                     end
                  end
                  default: begin
                     if (a_oor) begin
                        res_status_in = ST_OOR;
                     end else begin
                        other_in = NW'(req_node_a);
                        state_in = S_RD;
                     end
                  end
               endcase
            end
         end

         S_RD: begin
            reach_in    = dvalid_ff[other_ff];
            res_dist_in = dvalid_ff[other_ff] ? dist_rd : '0;
            state_in    = S_DONE;
         end

         // find the unsettled reached node of least distance, lowest index wins ties
         S_SCAN: begin
            dist_ra = scan_ff[NW-1:0];
            if (scan_ff != '0) begin
               if (dvalid_ff[prev_idx] && !settled_ff[prev_idx] &&
                   (!found_ff || dist_rd < bestd_ff)) begin
                  found_in = 1'b1;
                  best_in  = prev_idx;
                  bestd_in = dist_rd;
               end
            end
            if (scan_ff == (NW+1)'(MAX_NODES)) begin
               if (found_in) begin
                  settled_in[best_in] = 1'b1;
                  e_in                = '0;
                  if (edge_total_ff == '0) begin
                     scan_in  = '0;
                     found_in = 1'b0;
                  end else begin
                     state_in = S_RELAX_A;
                  end
               end else begin
                  k_in     = KW'(1);
                  sum_in   = '0;
                  reach_in = 1'b1;
                  state_in = S_SUM;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         S_RELAX_A: begin
            state_in = S_RELAX_B;
         end

         S_RELAX_B: begin
            other_in = (ea == best_ff) ? eb : ea;
            w_in     = ew;
            dist_ra  = (ea == best_ff) ? eb : ea;
            if (hit) begin
               state_in = S_RELAX_C;
            end else if (last_edge) begin
               scan_in  = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end else begin
               e_in     = e_ff + 1'b1;
               state_in = S_RELAX_A;
            end
         end

         S_RELAX_C: begin
            if (!dvalid_ff[other_ff] || nd < dist_rd) begin
               dist_we             = 1'b1;
               dvalid_in[other_ff] = 1'b1;
            end
            if (last_edge) begin
               scan_in  = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end else begin
               e_in     = e_ff + 1'b1;
               state_in = S_RELAX_A;
            end
         end

         // sum nodes 1..node_count; read of k overlaps accumulate of k-1
         S_SUM: begin
            dist_ra = NW'(k_ff);
            if (k_ff > KW'(1)) begin
               if ((CMP_BITS'(k_prev) < CMP_BITS'(MAX_NODES)) && dvalid_ff[sum_idx]) begin
                  sum_in = sum_ff + SUM_BITS'(dist_rd);
               end else begin
                  reach_in = 1'b0;
               end
            end
            if (k_ff == k_last) begin
               state_in = S_DONE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = res_status_ff;
               rsp_distance_in  = res_dist_ff;
               rsp_reachable_in = reach_ff;
               rsp_sum_in       = sum_ff;
               state_in         = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         source_ff     <= SOURCE_RST;
         count_ff      <= COUNT_RST;
         edge_total_ff <= '0;
         dvalid_ff     <= '0;
         settled_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         source_ff     <= source_in;
         count_ff      <= count_in;
         edge_total_ff <= edge_total_in;
         dvalid_ff     <= dvalid_in;
         settled_ff    <= settled_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      scan_ff          <= scan_in;
      found_ff         <= found_in;
      best_ff          <= best_in;
      bestd_ff         <= bestd_in;
      e_ff             <= e_in;
      other_ff         <= other_in;
      w_ff             <= w_in;
      k_ff             <= k_in;
      sum_ff           <= sum_in;
      reach_ff         <= reach_in;
      res_status_ff    <= res_status_in;
      res_dist_ff      <= res_dist_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_distance_ff  <= rsp_distance_in;
      rsp_reachable_ff <= rsp_reachable_in;
      rsp_sum_ff       <= rsp_sum_in;
   end

   // per-node tentative distances
   ssp_ram #(
      .WIDTH     (DIST_BITS),
      .DEPTH     (MAX_NODES),
      .ADDR_BITS (NW)
   ) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_wa),
      .wr_data (dist_wd),
      .rd_addr (dist_ra),
      .rd_data (dist_rd)
   );

   // edge list {a, b, weight}
   ssp_ram #(
      .WIDTH     (EWID),
      .DEPTH     (MAX_EDGES),
      .ADDR_BITS (EAW)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_total_ff[EAW-1:0]),
      .wr_data (edge_wd),
      .rd_addr (e_ff[EAW-1:0]),
      .rd_data (edge_rd)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_distance     = rsp_distance_ff;
   assign rsp_reachable    = rsp_reachable_ff;
   assign rsp_distance_sum = rsp_sum_ff;
endmodule : single_source_shortest_path
`default_nettype wire

// ===== sv/ssp_checker.sv =====
// Port-level checks for the shortest-path engine, bound to the top level.
`default_nettype none
module ssp_checker
   import ssp_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic [1:0]           rsp_status,
   input wire logic [DIST_BITS-1:0] rsp_distance,
   input wire logic                 rsp_reachable,
   input wire logic [SUM_BITS-1:0]  rsp_distance_sum
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_distance) && $stable(rsp_distance_sum))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != ST_BAD)
      else $error("undefined status code");

   a_error_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
      rsp_distance == '0 && !rsp_reachable && rsp_distance_sum == '0)
      else $error("error response carries data");

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reachable |-> rsp_distance == '0)
      else $error("unreachable node with distance");

   a_sum_xor_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_distance_sum != '0 |-> rsp_distance == '0)
      else $error("sum and distance both set");
endmodule : ssp_checker

bind single_source_shortest_path ssp_checker u_ssp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_distance     (rsp_distance),
   .rsp_reachable    (rsp_reachable),
   .rsp_distance_sum (rsp_distance_sum)
);
`default_nettype wire

// ===== bench/single_source_shortest_path_test.sv =====
// Self-checking bench for the shortest-path engine: directed cases, random graphs, stalls.
`default_nettype none
module single_source_shortest_path_test;
   import ssp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES      = 256;
   localparam int EDGES      = 512;
   localparam int IDLE_LIMIT = 500000;   // cycles with no handshake on either side
   localparam int RANDOM_REQUESTS = 1150;
   localparam logic [1:0] CSR_SPARE = 2'd2;  // unused register slot, must be ignored
   localparam logic [1:0] CSR_LAST  = 2'd3;

   typedef struct packed {
      logic [1:0]          status;
      logic [DIST_BITS-1:0] distance;
      logic                reachable;
      logic [SUM_BITS-1:0] distance_sum;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = '0;
   logic [7:0] req_node_a = '0;
   logic [7:0] req_node_b = '0;
   logic [15:0] req_weight = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [DIST_BITS-1:0] rsp_distance;
   logic rsp_reachable;
   logic [SUM_BITS-1:0] rsp_distance_sum;

   single_source_shortest_path uut (.*);

   always #5 clock = ~clock;

   // ---- predictor state: its own copy of graph, distances and registers ----
   logic [7:0]  edge_a [EDGES];
   logic [7:0]  edge_b [EDGES];
   logic [15:0] edge_w [EDGES];
   int          edge_cnt;
   logic [23:0] node_dist [NODES];
   bit          node_reached [NODES];
   logic [7:0]  source_reg;
   logic [7:0]  count_reg;

   response_type pending_responses[$];
   int mismatches = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int solves_sent = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold = 0;        // long receiver hold-off, counted down below
   int quiet_cycles = 0;

   function automatic void forget_distances();
      for (int i = 0; i < NODES; i++) begin
         node_reached[i] = 1'b0;
         node_dist[i] = '0;
      end
   endfunction

   // Dijkstra: pick unsettled reached node of least distance (lowest index on ties),
   // then relax every stored edge touching it, in store order.
   function automatic void run_dijkstra(logic [7:0] src);
      bit settled [NODES];
      int best;
      longint unsigned best_d, cand;
      int other;
      forget_distances();
      for (int i = 0; i < NODES; i++) settled[i] = 1'b0;
      node_reached[src] = 1'b1;
      for (int round = 0; round < NODES; round++) begin
         best = -1;
         best_d = 0;
         for (int i = 0; i < NODES; i++)
            if (!settled[i] && node_reached[i] && (best < 0 || node_dist[i] < best_d)) begin
               best = i;
               best_d = node_dist[i];
            end
         if (best < 0) break;
         settled[best] = 1'b1;
         for (int e = 0; e < edge_cnt; e++) begin
            if (edge_a[e] == best) other = edge_b[e];
            else if (edge_b[e] == best) other = edge_a[e];
            else continue;
            cand = best_d + edge_w[e];
            if (cand > DIST_MAX) cand = DIST_MAX;
            if (!node_reached[other] || cand < node_dist[other]) begin
               node_reached[other] = 1'b1;
               node_dist[other] = cand[23:0];
            end
         end
      end
   endfunction

   function automatic response_type compute_response(logic [1:0] cmd, logic [7:0] a,
                                                     logic [7:0] b, logic [15:0] w);
      response_type r;
      longint unsigned total;
      r = '0;
      case (cmd)
         CMD_CLEAR: begin
            edge_cnt = 0;
            forget_distances();
         end
         CMD_ADD: begin
            // 8-bit endpoints are always in range with 256 nodes
            if (edge_cnt >= EDGES) r.status = ST_FULL;
            else begin
               edge_a[edge_cnt] = a;
               edge_b[edge_cnt] = b;
               edge_w[edge_cnt] = w;
               edge_cnt++;
            end
         end
         CMD_SOLVE: begin
            run_dijkstra(source_reg);
            total = 0;
            r.reachable = 1'b1;
            for (int n = 1; n <= count_reg; n++)
               if (!node_reached[n]) r.reachable = 1'b0;
               else total += node_dist[n];
            if (total > 64'h1_FFFF_FFFF) total = 64'h1_FFFF_FFFF;
            r.distance_sum = total[SUM_BITS-1:0];
         end
         default: begin
            if (node_reached[a]) begin
               r.distance = node_dist[a];
               r.reachable = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   // ---- receiver side: random stall plus an optional long hold ----
   always @(posedge clock) begin
      if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // Sample at the falling edge: stall/valid are stable until the next rising edge,
   // where the response is taken.
   always @(negedge clock) begin
      response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (pending_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response status=%0d dist=%0d reach=%0d sum=%0d",
                        rsp_status, rsp_distance, rsp_reachable, rsp_distance_sum);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_status !== want.status || rsp_distance !== want.distance ||
                rsp_reachable !== want.reachable ||
                rsp_distance_sum !== want.distance_sum) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"ERROR: response %0d exp st=%0d d=%0d r=%0d s=%0d",
                            " got st=%0d d=%0d r=%0d s=%0d"},
                           responses_seen, want.status, want.distance, want.reachable,
                           want.distance_sum, rsp_status, rsp_distance, rsp_reachable,
                           rsp_distance_sum);
            end
         end
      end
   end

   // Watchdog: any stretch without a handshake this long means the block hung.
   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else if (++quiet_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d quiet cycles", quiet_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // Offer one request; returns at the rising edge where it was taken.
   // Valid stays high afterwards so back-to-back requests follow without dropping it.
   task automatic send_request(logic [1:0] cmd, logic [7:0] a, logic [7:0] b,
                               logic [15:0] w);
      bit taken;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_node_a <= a;
      req_node_b <= b;
      req_weight <= w;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      pending_responses.insert(pending_responses.size(), compute_response(cmd, a, b, w));
      requests_sent++;
      if (cmd == CMD_SOLVE) solves_sent++;
   endtask

   // Stop offering and wait for every outstanding response, plus a short tail.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_SOURCE) source_reg = val;
      else if (idx == CSR_COUNT) count_reg = val;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom_range(0, 15));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Distances read before any solve: every node unreachable; solve on empty graph.
   task automatic test_fresh_state();
      send_request(CMD_READ, 8'd0, 8'd0, 16'd0);
      send_request(CMD_READ, 8'd1, 8'hFF, 16'hFFFF);
      send_request(CMD_READ, 8'd255, 8'd0, 16'd0);
      send_request(CMD_SOLVE, 8'd0, 8'd0, 16'd0);
      send_request(CMD_READ, 8'd1, 8'd0, 16'd0);
      send_request(CMD_READ, 8'd2, 8'd0, 16'd0);
      drain();
   endtask

   // Small hand-built graph: self loop, zero and full weights, nodes 0 and 255,
   // parallel edges, zero node count and both source extremes.
   task automatic test_directed_graph();
      send_request(CMD_CLEAR, 8'hFF, 8'hFF, 16'hFFFF);
      send_request(CMD_ADD, 8'd0, 8'd1, 16'd0);
      send_request(CMD_ADD, 8'd1, 8'd2, 16'hFFFF);
      send_request(CMD_ADD, 8'd2, 8'd2, 16'd7);        // self loop
      send_request(CMD_ADD, 8'd2, 8'd255, 16'd3);
      send_request(CMD_ADD, 8'd0, 8'd2, 16'd100);      // shorter route to 2
      send_request(CMD_ADD, 8'd2, 8'd0, 16'd50);       // parallel, shorter still
      drain();
      write_reg(CSR_SOURCE, 8'd0);
      write_reg(CSR_COUNT, 8'd3);
      write_reg(CSR_SPARE, 8'hAA);
      write_reg(CSR_LAST, 8'h55);
      send_request(CMD_SOLVE, 8'd0, 8'd0, 16'd0);
      send_request(CMD_READ, 8'd0, 8'd0, 16'd0);
      send_request(CMD_READ, 8'd2, 8'd0, 16'd0);
      send_request(CMD_READ, 8'd255, 8'd0, 16'd0);
      send_request(CMD_READ, 8'd3, 8'd0, 16'd0);
      drain();
      write_reg(CSR_COUNT, 8'd0);   // empty sum: reachable, zero
      send_request(CMD_SOLVE, 8'd0, 8'd0, 16'd0);
      drain();
      write_reg(CSR_SOURCE, 8'd255);
      write_reg(CSR_COUNT, 8'd255);
      send_request(CMD_SOLVE, 8'd0, 8'd0, 16'd0);
      send_request(CMD_READ, 8'd1, 8'd0, 16'd0);
      send_request(CMD_CLEAR, 8'd0, 8'd0, 16'd0);
      send_request(CMD_READ, 8'd255, 8'd0, 16'd0);   // cleared: unreachable again
      drain();
   endtask

   // Fill the edge store among four nodes, overflow it, then solve on the full store.
   task automatic test_store_full();
      write_reg(CSR_SOURCE, 8'd0);
      write_reg(CSR_COUNT, 8'd3);
      send_request(CMD_CLEAR, 8'd0, 8'd0, 16'd0);
      for (int i = 0; i < EDGES; i++)
         send_request(CMD_ADD, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                      pick_weight());
      send_request(CMD_ADD, 8'd0, 8'd1, 16'd1);
      send_request(CMD_ADD, 8'd2, 8'd3, 16'd1);
      send_request(CMD_SOLVE, 8'd0, 8'd0, 16'd0);
      for (int i = 0; i < 4; i++) send_request(CMD_READ, 8'(i), 8'd0, 16'd0);
      send_request(CMD_CLEAR, 8'd0, 8'd0, 16'd0);
      drain();
   endtask

   // Receiver holds off for a long stretch while requests keep coming, so the
   // block backs up and stalls its input; then the sender waits for everything.
   task automatic test_backpressure();
      rx_hold = 300;
      for (int i = 0; i < 20; i++)
         send_request(i % 3 == 0 ? CMD_READ : CMD_ADD, 8'($urandom_range(0, 7)),
                      8'($urandom_range(0, 7)), pick_weight());
      send_request(CMD_SOLVE, 8'd0, 8'd0, 16'd0);
      drain();
   endtask

   // One random graph episode: new registers, a clear in most episodes, edges within a
   // window of nodes, stray reads, a solve and a handful of reads.
   task automatic random_episode();
      int base, span, n_edges;
      base = $urandom_range(0, 243);
      span = $urandom_range(2, 12);
      n_edges = $urandom_range(0, 14);
      drain();
      write_reg(CSR_SOURCE, $urandom_range(3) == 0 ? 8'($urandom_range(0, 255))
                                                   : 8'(base + $urandom_range(0, span - 1)));
      case ($urandom_range(5))
         0: write_reg(CSR_COUNT, 8'd255);
         1: write_reg(CSR_COUNT, 8'($urandom_range(0, 1)));
         default: write_reg(CSR_COUNT, 8'($urandom_range(0, base + span)));
      endcase
      if ($urandom_range(4) != 0)
         send_request(CMD_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom));
      for (int i = 0; i < n_edges; i++) begin
         if ($urandom_range(9) == 0)
            send_request(CMD_READ, 8'($urandom), 8'($urandom), 16'($urandom));
         send_request(CMD_ADD, 8'(base + $urandom_range(0, span - 1)),
                      8'(base + $urandom_range(0, span - 1)), pick_weight());
      end
      send_request(CMD_SOLVE, 8'($urandom), 8'($urandom), 16'($urandom));
      repeat ($urandom_range(1, 6))
         send_request(CMD_READ, $urandom_range(1) ? 8'(base + $urandom_range(0, span))
                                                  : 8'($urandom_range(0, 255)),
                      8'($urandom), 16'($urandom));
   endtask

   task automatic test_random_graphs();
      int goal;
      goal = requests_sent + RANDOM_REQUESTS;
      for (int stage = 0; stage < 3; stage++) begin
         tx_idle_pct = (stage == 0) ? 30 : (stage == 1) ? 74 : 0;
         rx_idle_pct = (stage == 0) ? 74 : (stage == 1) ? 30 : 0;
         while (requests_sent < goal - (2 - stage) * RANDOM_REQUESTS / 3)
            random_episode();
      end
      drain();
   endtask

   initial begin
      edge_cnt = 0;
      forget_distances();
      source_reg = SOURCE_RST;
      count_reg = COUNT_RST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fresh_state();
      test_directed_graph();
      test_store_full();
      test_backpressure();
      test_random_graphs();
      repeat (20) @(posedge clock);
      $display("Ran %0d requests (%0d solves) over directed graphs, a full edge store,",
               requests_sent, solves_sent);
      $display("random windowed graphs and several stall patterns; %0d responses checked.",
               responses_seen);
      if (mismatches == 0 && pending_responses.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire
